// File: rtl/skvt_pkg.sv
`timescale 1ns / 1ps

package skvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_ADD    = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_MISSING = 2'd1;
    localparam status_t ST_PRESENT = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   value_out;
        logic [COUNT_W-1:0]   entry_count;
    } result_t;

endpackage

// File: rtl/skvt_outbuf.sv
`timescale 1ns / 1ps

module skvt_outbuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  skvt_pkg::result_t res_in,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output skvt_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    skvt_pkg::result_t res_reg;

    // free when empty or when the held result leaves this cycle
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// File: rtl/sorted_key_value_table.sv
`timescale 1ns / 1ps

// channel   signals                          payload
// -------   ------------------------------   ---------------------------------
// in        in_valid / in_stall (to sender)  op, key, value
// out       out_valid / out_stall (from dst) status, value_out, entry_count
//
// one request at a time: binary search, each probe a read then a compare,
// then the result is loaded into the output register once that is free
// add and remove first move one entry per cycle, between search and load
// reset empties the table at once (entry count only, no clearing pass)
// in_stall is high from acceptance until the result is loaded into the
// output register; a waiting result does not block the next request

module sorted_key_value_table
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [4:0]  entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRCH   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic        hit_reg, hit_next;
    logic        pend_reg, pend_next;

    skvt_pkg::op_t req_op_reg, req_op_next;
    logic [31:0]   req_key_reg, req_key_next;
    logic [31:0]   req_value_reg, req_value_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] sh_dst_reg, sh_dst_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [31:0]   hit_val_reg, hit_val_next;
    skvt_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]   res_vout_reg, res_vout_next;

    // entry memory, one write and one registered read per cycle
    skvt_pkg::entry_t entry_mem [TABLE_DEPTH];
    skvt_pkg::entry_t rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    skvt_pkg::entry_t mem_wd;
    logic [AW-1:0]    mem_ra;

    logic             in_accept;
    logic             out_load;
    logic             out_ready;
    logic [CW-1:0]    mid_calc;
    logic [CW-1:0]    rd_dn;
    logic [CW-1:0]    rd_up;
    logic             is_add;
    logic             is_remove;
    skvt_pkg::result_t res_in;
    skvt_pkg::result_t res_out;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign is_add    = (req_op_reg == skvt_pkg::OP_ADD);
    assign is_remove = (req_op_reg == skvt_pkg::OP_REMOVE);
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_dn     = sh_dst_reg - ONE_C;
    assign rd_up     = sh_dst_reg + ONE_C;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        pend_next       = 1'b0;
        req_op_next     = req_op_reg;
        req_key_next    = req_key_reg;
        req_value_next  = req_value_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        sh_dst_next     = sh_dst_reg;
        wa_next         = wa_reg;
        hit_val_next    = hit_val_reg;
        res_status_next = res_status_reg;
        res_vout_next   = res_vout_reg;
        mem_we          = 1'b0;
        mem_wa          = wa_reg;
        mem_wd          = rd_data_reg;
        mem_ra          = mid_calc[AW-1:0];
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_op_next    = op;
                    req_key_next   = key;
                    req_value_next = value;
                    lo_next        = '0;
                    hi_next        = count_reg;
                    hit_next       = 1'b0;
                    hit_val_next   = '0;
                    state_next     = S_SRCH;
                end
            end

            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    pos_next        = lo_reg;
                    res_status_next = skvt_pkg::ST_OK;
                    res_vout_next   = '0;
                    if (is_add)
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = skvt_pkg::ST_PRESENT;
                            state_next      = S_FINISH;
                        end
                        else if (count_reg >= DEPTH_C)
                        begin
                            res_status_next = skvt_pkg::ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            sh_dst_next = count_reg;
                            state_next  = S_SHIFT;
                        end
                    end
                    else if (is_remove)
                    begin
                        if (!hit_reg)
                        begin
                            res_status_next = skvt_pkg::ST_MISSING;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            res_vout_next = hit_val_reg;
                            sh_dst_next   = lo_reg;
                            state_next    = S_SHIFT;
                        end
                    end
                    else
                    begin
                        // lookup, and the unused op code
                        if (hit_reg)
                        begin
                            res_vout_next = hit_val_reg;
                        end
                        else
                        begin
                            res_status_next = skvt_pkg::ST_MISSING;
                        end
                        state_next = S_FINISH;
                    end
                end
            end

            S_CMP:
            begin
                // keys are unique, so a match marks the final position
                if (rd_data_reg.key == req_key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_val_next = rd_data_reg.value;
                end
                if (rd_data_reg.key < req_key_reg)
                begin
                    lo_next = mid_reg + ONE_C;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end

            S_SHIFT:
            begin
                // write of the entry read last cycle
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = wa_reg;
                    mem_wd = rd_data_reg;
                end
                if (is_add)
                begin
                    if (sh_dst_reg > pos_reg)
                    begin
                        mem_ra      = rd_dn[AW-1:0];
                        wa_next     = sh_dst_reg[AW-1:0];
                        pend_next   = 1'b1;
                        sh_dst_next = rd_dn;
                    end
                    else if (!pend_reg)
                    begin
                        mem_we       = 1'b1;
                        mem_wa       = pos_reg[AW-1:0];
                        mem_wd.key   = req_key_reg;
                        mem_wd.value = req_value_reg;
                        count_next   = count_reg + ONE_C;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    if (rd_up < count_reg)
                    begin
                        mem_ra      = rd_up[AW-1:0];
                        wa_next     = sh_dst_reg[AW-1:0];
                        pend_next   = 1'b1;
                        sh_dst_next = rd_up;
                    end
                    else if (!pend_reg)
                    begin
                        count_next = count_reg - ONE_C;
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            hit_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_op_reg     <= req_op_next;
        req_key_reg    <= req_key_next;
        req_value_reg  <= req_value_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        sh_dst_reg     <= sh_dst_next;
        wa_reg         <= wa_next;
        hit_val_reg    <= hit_val_next;
        res_status_reg <= res_status_next;
        res_vout_reg   <= res_vout_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[mem_ra];
    end

    always_comb
    begin
        res_in.status      = res_status_reg;
        res_in.value_out   = res_vout_reg;
        res_in.entry_count = skvt_pkg::COUNT_W'(count_reg);
    end

    skvt_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .res_in    (res_in),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign status      = res_out.status;
    assign value_out   = res_out.value_out;
    assign entry_count = res_out.entry_count;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_SHIFT))
        else $error("entry count changed outside a shift");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH || state_reg == S_CMP) |-> (lo_reg <= hi_reg))
        else $error("search window inverted");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_FINISH))
        else $error("result shown without a finished request");

endmodule
